FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CHK_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// checked on every clock edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/sfrs_pkg.sv
// shared constants, types and codes of the spi flash read slave
package sfrs_pkg;

   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int PTR_W     = 25;

   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_DUAL  = 8'hbb;
   localparam logic [7:0] OP_QUAD  = 8'heb;
   localparam logic [7:0] OP_WREN  = 8'h50;
   localparam logic [7:0] OP_RDSR2 = 8'h35;
   localparam logic [7:0] OP_WRSR2 = 8'h31;

   localparam logic [7:0] SR2_READ_VALUE = 8'hfd;
   localparam logic [7:0] CONT_MASK      = 8'h30;
   localparam logic [7:0] CONT_MATCH     = 8'h20;
   localparam logic [2:0] QUAD_DUMMY     = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_PARTIAL  = 3'd1;
   localparam logic [2:0] ERR_CLOCK    = 3'd2;
   localparam logic [2:0] ERR_UNDEF_RD = 3'd3;
   localparam logic [2:0] ERR_BAD_CMD  = 3'd4;
   localparam logic [2:0] ERR_NO_WREN  = 3'd5;

   typedef enum logic [6:0] {
      PH_CMD   = 7'b0000001,
      PH_ADDR  = 7'b0000010,
      PH_MODE  = 7'b0000100,
      PH_DUMMY = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_RDREG = 7'b0100000,
      PH_WRREG = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      CMD_UNDEF = 3'd0,
      CMD_READ  = 3'd1,
      CMD_DUAL  = 3'd2,
      CMD_QUAD  = 3'd3,
      CMD_WREN  = 3'd4,
      CMD_RDSR2 = 3'd5,
      CMD_WRSR2 = 3'd6
   } command_type;

   typedef enum logic [1:0] {
      LANE_SINGLE = 2'd0,
      LANE_DUAL   = 2'd1,
      LANE_QUAD   = 2'd2,
      LANE_SPARE  = 2'd3
   } lane_type;

   typedef struct packed {
      logic [3:0] io_out;
      logic [3:0] output_enable;
      logic [2:0] error_code;
      logic [7:0] status_two;
   } result_type;

endpackage

FILE: rtl/core/sfrs_ram.sv
// generic single write, single read ram with registered read data
module sfrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sfrs_core.sv
// pin tracking, command decode and flash byte store
module sfrs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                mode,
   input  logic                pin_csn,
   input  logic                pin_clk,
   input  logic [3:0]          io_in,
   input  logic [15:0]         load_addr,
   input  logic [7:0]          load_data,
   output logic                busy,
   output sfrs_pkg::result_type result
);
   import sfrs_pkg::*;

   logic              last_csn_ff, last_csn_in;
   logic              last_clk_ff, last_clk_in;
   logic              clk_rel_ff, clk_rel_in;
   logic              was_sel_ff, was_sel_in;
   phase_type         phase_ff, phase_in;
   command_type       cmd_ff, cmd_in;
   lane_type          lane_ff, lane_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [7:0]        si_ff, si_in;
   logic [7:0]        so_ff, so_in;
   logic [3:0]        bc_ff, bc_in;
   logic [1:0]        byc_ff, byc_in;
   logic [2:0]        dl_ff, dl_in;
   logic              cont_ff, cont_in;
   logic              wen_ff, wen_in;
   logic [7:0]        sr2_ff, sr2_in;
   logic [3:0]        de_ff, de_in;
   logic [3:0]        dv_ff, dv_in;

   logic              clr_ff, clr_in;
   logic [MEM_AW:0]   clr_cnt_ff, clr_cnt_in;
   logic              fwd_ff;
   logic [8:0]        fwd_data_ff;

   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr, ram_raddr;
   logic [8:0]        ram_wdata, ram_q, entry;
   logic              load_we;
   logic [PTR_W-1:0]  load_ext;

   logic [2:0]        err;
   logic [3:0]        io_res;
   logic [4:0]        bc_sum;
   logic [7:0]        tb_si;
   logic [3:0]        tb_bc;
   logic [1:0]        tb_byc;
   logic              rise, fall;

   sfrs_ram #(.WIDTH(9), .DEPTH(MEM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign entry    = fwd_ff ? fwd_data_ff : ram_q;
   assign load_ext = PTR_W'(load_addr);
   assign load_we  = accept && mode && (load_ext < PTR_W'(MEM_DEPTH));
   assign busy     = clr_ff;

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + (MEM_AW+1)'(1);
         if (clr_cnt_ff == (MEM_AW+1)'(MEM_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
      ram_we    = clr_ff || load_we;
      ram_waddr = clr_ff ? clr_cnt_ff[MEM_AW-1:0] : load_ext[MEM_AW-1:0];
      ram_wdata = clr_ff ? 9'd0 : {1'b1, load_data};
      ram_raddr = rp_in[MEM_AW-1:0];
   end

   always_comb begin
      last_csn_in = last_csn_ff;
      last_clk_in = last_clk_ff;
      clk_rel_in  = clk_rel_ff;
      was_sel_in  = was_sel_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      lane_in     = lane_ff;
      rp_in       = rp_ff;
      si_in       = si_ff;
      so_in       = so_ff;
      bc_in       = bc_ff;
      byc_in      = byc_ff;
      dl_in       = dl_ff;
      cont_in     = cont_ff;
      wen_in      = wen_ff;
      sr2_in      = sr2_ff;
      de_in       = de_ff;
      dv_in       = dv_ff;
      err         = ERR_NONE;
      io_res      = dv_ff;
      tb_si       = si_ff;
      tb_bc       = bc_ff;
      tb_byc      = byc_ff;
      bc_sum      = 5'd0;
      rise        = 1'b0;
      fall        = 1'b0;

      if (accept && !mode) begin
         last_csn_in = pin_csn;
         if (last_csn_ff && pin_csn) begin
            io_res = 4'd0;
         end else begin
            last_clk_in = pin_clk;
            if (pin_csn && !last_csn_ff) begin
               de_in      = 4'd0;
               clk_rel_in = pin_clk;
               if (bc_ff != 4'd0) begin
                  err = ERR_PARTIAL;
               end
            end else if (!pin_csn && last_csn_ff) begin
               phase_in = cont_ff ? PH_ADDR : PH_CMD;
               if (!cont_ff) begin
                  cmd_in  = CMD_UNDEF;
                  lane_in = LANE_SINGLE;
               end
               rp_in  = '0;
               si_in  = 8'd0;
               byc_in = 2'd0;
               bc_in  = 4'd0;
               de_in  = 4'd0;
               if (was_sel_ff && (clk_rel_ff != pin_clk)) begin
                  err = ERR_CLOCK;
               end
               was_sel_in = 1'b1;
            end
            rise = !pin_csn && pin_clk && !last_clk_ff;
            fall = !pin_csn && !pin_clk && last_clk_ff;

            // bit intake shared by the shifting phases
            if (phase_in == PH_CMD || lane_in == LANE_SINGLE || lane_in == LANE_SPARE) begin
               tb_si  = {si_in[6:0], io_in[0]};
               bc_sum = {1'b0, bc_in} + 5'd1;
            end else if (lane_in == LANE_DUAL) begin
               tb_si  = {si_in[5:0], io_in[1:0]};
               bc_sum = {1'b0, bc_in} + 5'd2;
            end else begin
               tb_si  = {si_in[3:0], io_in};
               bc_sum = {1'b0, bc_in} + 5'd4;
            end
            tb_bc  = bc_sum[3:0];
            tb_byc = byc_in;
            if (bc_sum >= 5'd8) begin
               tb_bc = 4'd0;
               if (byc_in != 2'd3) begin
                  tb_byc = byc_in + 2'd1;
               end
            end

            if (rise) begin
               unique case (phase_in)
                  PH_CMD: begin
                     si_in  = tb_si;
                     bc_in  = tb_bc;
                     byc_in = tb_byc;
                     if (tb_byc == 2'd1) begin
                        unique case (tb_si)
                           OP_READ: begin
                              cmd_in = CMD_READ; lane_in = LANE_SINGLE;
                              phase_in = PH_ADDR; byc_in = 2'd0;
                           end
                           OP_DUAL: begin
                              cmd_in = CMD_DUAL; lane_in = LANE_DUAL;
                              phase_in = PH_ADDR; byc_in = 2'd0;
                           end
                           OP_QUAD: begin
                              cmd_in = CMD_QUAD; lane_in = LANE_QUAD;
                              phase_in = PH_ADDR; byc_in = 2'd0;
                           end
                           OP_WREN: begin
                              cmd_in = CMD_WREN; wen_in = 1'b1;
                           end
                           OP_RDSR2: begin
                              cmd_in = CMD_RDSR2; lane_in = LANE_SINGLE;
                              phase_in = PH_RDREG; byc_in = 2'd0;
                              so_in = SR2_READ_VALUE;
                           end
                           OP_WRSR2: begin
                              cmd_in = CMD_WRSR2;
                              if (wen_in) begin
                                 lane_in = LANE_SINGLE;
                                 phase_in = PH_WRREG; byc_in = 2'd0;
                              end else begin
                                 err = ERR_NO_WREN;
                              end
                           end
                           default: begin
                              cmd_in = CMD_UNDEF; err = ERR_BAD_CMD;
                              lane_in = LANE_SINGLE;
                              phase_in = PH_CMD; byc_in = 2'd0;
                           end
                        endcase
                     end
                  end
                  PH_ADDR: begin
                     si_in  = tb_si;
                     bc_in  = tb_bc;
                     byc_in = tb_byc;
                     if (tb_bc == 4'd0) begin
                        rp_in = {rp_in[PTR_W-9:0], tb_si};
                     end
                     if (tb_byc == 2'd3) begin
                        byc_in   = 2'd0;
                        phase_in = (cmd_in == CMD_DUAL || cmd_in == CMD_QUAD) ?
                                   PH_MODE : PH_DATA;
                     end
                  end
                  PH_MODE: begin
                     si_in  = tb_si;
                     bc_in  = tb_bc;
                     byc_in = tb_byc;
                     if (tb_byc == 2'd1) begin
                        cont_in = ((tb_si & CONT_MASK) == CONT_MATCH);
                        byc_in  = 2'd0;
                        if (cmd_in == CMD_QUAD) begin
                           phase_in = PH_DUMMY;
                           dl_in    = QUAD_DUMMY;
                        end else begin
                           phase_in = PH_DATA;
                           dl_in    = 3'd0;
                        end
                     end
                  end
                  PH_DUMMY: begin
                     if (dl_in <= 3'd1) begin
                        dl_in    = 3'd0;
                        byc_in   = 2'd0;
                        phase_in = PH_DATA;
                     end else begin
                        dl_in = dl_in - 3'd1;
                     end
                  end
                  PH_WRREG: begin
                     si_in  = tb_si;
                     bc_in  = tb_bc;
                     byc_in = tb_byc;
                     if (tb_byc == 2'd1) begin
                        wen_in = 1'b0;
                        sr2_in = tb_si;
                     end
                  end
                  PH_DATA, PH_RDREG: begin
                  end
               endcase
               dv_in = 4'd0;
            end else if (fall && (phase_in == PH_DATA || phase_in == PH_RDREG)) begin
               if (phase_in == PH_DATA && bc_in == 4'd0) begin
                  if (rp_in[PTR_W-1:MEM_AW] == '0 && entry[8]) begin
                     so_in = entry[7:0];
                     rp_in = rp_in + PTR_W'(1);
                  end else begin
                     err   = ERR_UNDEF_RD;
                     so_in = 8'd0;
                  end
               end
               case (lane_in)
                  LANE_DUAL: begin
                     dv_in  = {2'b00, so_in[7:6]};
                     so_in  = {so_in[5:0], 2'b00};
                     bc_sum = {1'b0, bc_in} + 5'd2;
                     de_in  = 4'd3;
                  end
                  LANE_QUAD: begin
                     dv_in  = so_in[7:4];
                     so_in  = {so_in[3:0], 4'b0000};
                     bc_sum = {1'b0, bc_in} + 5'd4;
                     de_in  = 4'd15;
                  end
                  default: begin
                     dv_in  = {2'b00, so_in[7], 1'b0};
                     so_in  = {so_in[6:0], 1'b0};
                     bc_sum = {1'b0, bc_in} + 5'd1;
                     de_in  = 4'd2;
                  end
               endcase
               bc_in = (bc_sum >= 5'd8) ? 4'd0 : bc_sum[3:0];
            end
            io_res = dv_in;
         end
      end

      result.io_out        = io_res;
      result.output_enable = de_in;
      result.error_code    = err;
      result.status_two    = sr2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_csn_ff <= 1'b1;
         last_clk_ff <= 1'b0;
         clk_rel_ff  <= 1'b0;
         was_sel_ff  <= 1'b0;
         phase_ff    <= PH_CMD;
         cmd_ff      <= CMD_UNDEF;
         lane_ff     <= LANE_SINGLE;
         rp_ff       <= '0;
         si_ff       <= 8'd0;
         so_ff       <= 8'd0;
         bc_ff       <= 4'd0;
         byc_ff      <= 2'd0;
         dl_ff       <= 3'd0;
         cont_ff     <= 1'b0;
         wen_ff      <= 1'b0;
         sr2_ff      <= 8'd0;
         de_ff       <= 4'd0;
         dv_ff       <= 4'd0;
         clr_ff      <= 1'b1;
         clr_cnt_ff  <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         last_csn_ff <= last_csn_in;
         last_clk_ff <= last_clk_in;
         clk_rel_ff  <= clk_rel_in;
         was_sel_ff  <= was_sel_in;
         phase_ff    <= phase_in;
         cmd_ff      <= cmd_in;
         lane_ff     <= lane_in;
         rp_ff       <= rp_in;
         si_ff       <= si_in;
         so_ff       <= so_in;
         bc_ff       <= bc_in;
         byc_ff      <= byc_in;
         dl_ff       <= dl_in;
         cont_ff     <= cont_in;
         wen_ff      <= wen_in;
         sr2_ff      <= sr2_in;
         de_ff       <= de_in;
         dv_ff       <= dv_in;
         clr_ff      <= clr_in;
         clr_cnt_ff  <= clr_cnt_in;
         fwd_ff      <= ram_we && (ram_waddr == ram_raddr);
      end
      fwd_data_ff <= ram_wdata;
   end

endmodule

FILE: rtl/core/sfrs_out_buf.sv
// result register with one skid stage
module sfrs_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfrs_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sfrs_pkg::result_type out_data
);
   import sfrs_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   assign take      = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: rtl/core/spi_flash_read_slave.sv
// top level of the spi nor flash read slave model
//
// req_ carries one word per cycle while req_stall is low: a pin snapshot
// (chip select, clock, io0..3) or, with req_mode high, a load of one flash
// byte at req_load_addr. rsp_ returns exactly one word per accepted request:
// flash io levels, drive enables, an error code and status register 2.
// each response is registered in the output buffer's main or skid register.
// throughput: one request per cycle while req_stall is low; the flash byte
// store's read port is registered and addressed with the next read pointer.
// at reset every byte is marked unloaded by a clearing pass over all MEM_DEPTH
// addresses (65536); req_stall is high during it.
// while rsp_stall is high one further request is held in a skid stage;
// req_stall then stays high until one waiting word is taken.
module spi_flash_read_slave (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_pin_csn,
   input  logic        req_pin_clk,
   input  logic [3:0]  req_io_in,
   input  logic [15:0] req_load_addr,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_io_out,
   output logic [3:0]  rsp_output_enable,
   output logic [2:0]  rsp_error_code,
   output logic [7:0]  rsp_status_two
);
   import sfrs_pkg::*;

   logic       accept, busy, full;
   result_type res, out_res;

   assign req_stall = busy || full;
   assign accept    = req_valid && !req_stall;

   sfrs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_mode),
      .pin_csn   (req_pin_csn),
      .pin_clk   (req_pin_clk),
      .io_in     (req_io_in),
      .load_addr (req_load_addr),
      .load_data (req_load_data),
      .busy      (busy),
      .result    (res)
   );

   sfrs_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_res)
   );

   assign rsp_io_out        = out_res.io_out;
   assign rsp_output_enable = out_res.output_enable;
   assign rsp_error_code    = out_res.error_code;
   assign rsp_status_two    = out_res.status_two;

endmodule

FILE: rtl/core/sfrs_checker.sv
// port level checks of the spi flash read slave and their binding
`include "assert_macros.svh"

module sfrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_output_enable,
   input logic [2:0] rsp_error_code,
   input logic [3:0] rsp_io_out
);

   logic oe_legal;

   assign oe_legal = (rsp_output_enable == 4'd0) || (rsp_output_enable == 4'd2) ||
                     (rsp_output_enable == 4'd3) || (rsp_output_enable == 4'd15);

   `CHK_ASSERT_ALWAYS(a_clear_after_reset, reset |=> req_stall)
   `CHK_ASSERT(a_word_follows_accept, (req_valid && !req_stall) |=> rsp_valid)
   `CHK_ASSERT(a_err_range, rsp_valid |-> (rsp_error_code <= 3'd5))
   `CHK_ASSERT(a_enable_codes, rsp_valid |-> oe_legal)
   `CHK_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_io_out)))

endmodule

bind spi_flash_read_slave sfrs_checker u_sfrs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_output_enable (rsp_output_enable),
   .rsp_error_code    (rsp_error_code),
   .rsp_io_out        (rsp_io_out)
);

FILE: test/tb_spi_flash_read_slave.sv
// self-checking testbench for the spi flash read slave: bus sequences, loads and a predictor
`timescale 1ns / 1ps

module tb_spi_flash_read_slave;
   import sfrs_pkg::*;

   typedef struct {
      bit         mode;
      bit         csn;
      bit         clk;
      logic [3:0] io;
      logic [15:0] addr;
      logic [7:0] data;
   } spi_sample_type;

   logic        clock, reset;
   logic        req_valid, req_stall, req_mode, req_pin_csn, req_pin_clk;
   logic [3:0]  req_io_in;
   logic [15:0] req_load_addr;
   logic [7:0]  req_load_data;
   logic        rsp_valid, rsp_stall;
   logic [3:0]  rsp_io_out, rsp_output_enable;
   logic [2:0]  rsp_error_code;
   logic [7:0]  rsp_status_two;

   spi_flash_read_slave dut (.*);

   spi_sample_type pending_samples[$];
   result_type  expected_responses[$];
   spi_sample_type cur_sample;
   bit          taken;
   int          gap_left, stall_run, hold_left;
   bit          hold_done;
   int          accepted, checked, mismatches;
   int          n_reads, n_status, n_loads, n_faults;

   // flash image and slave state as predicted
   logic [7:0]  flash_img [0:MEM_DEPTH-1];
   bit          loaded [0:MEM_DEPTH-1];
   bit          f_last_csn, f_last_clk, f_clk_rel, f_was_sel;
   phase_type   f_phase;
   command_type f_cmd;
   lane_type    f_lane;
   logic [PTR_W-1:0] f_ptr;
   logic [7:0]  f_sin, f_sout, f_sr2;
   int          f_bits, f_bytes, f_dummy;
   bit          f_cont, f_wen;
   logic [3:0]  f_de, f_dv;
   logic [2:0]  f_err;

   function automatic int lane_width();
      if (f_lane == LANE_DUAL) return 2;
      if (f_lane == LANE_QUAD) return 4;
      return 1;
   endfunction

   function automatic void enter_phase(phase_type ph);
      f_bytes = 0;
      f_phase = ph;
   endfunction

   function automatic void shift_in_bits(logic [3:0] io, int n);
      f_sin = 8'((int'(f_sin) << n) | (int'(io) & ((1 << n) - 1)));
      f_bits += n;
      if (f_bits >= 8) begin
         f_bits = 0;
         if (f_bytes < 3) f_bytes++;
      end
   endfunction

   function automatic logic [3:0] shift_out_bits();
      int n, top;
      n = lane_width();
      top = (int'(f_sout) >> (8 - n)) & ((1 << n) - 1);
      f_sout = 8'(int'(f_sout) << n);
      f_bits += n;
      if (f_bits >= 8) f_bits = 0;
      f_de = (n == 1) ? 4'd2 : 4'((1 << n) - 1);
      return (n == 1) ? 4'(top << 1) : 4'(top);
   endfunction

   function automatic void decode_opcode(logic [7:0] op);
      case (op)
         OP_READ: begin
            f_cmd = CMD_READ; f_lane = LANE_SINGLE; enter_phase(PH_ADDR);
         end
         OP_DUAL: begin
            f_cmd = CMD_DUAL; f_lane = LANE_DUAL; enter_phase(PH_ADDR);
         end
         OP_QUAD: begin
            f_cmd = CMD_QUAD; f_lane = LANE_QUAD; enter_phase(PH_ADDR);
         end
         OP_WREN: begin
            f_cmd = CMD_WREN; f_wen = 1;
         end
         OP_RDSR2: begin
            f_cmd = CMD_RDSR2; f_lane = LANE_SINGLE; enter_phase(PH_RDREG);
            f_sout = SR2_READ_VALUE;
         end
         OP_WRSR2: begin
            f_cmd = CMD_WRSR2;
            if (f_wen) begin
               f_lane = LANE_SINGLE; enter_phase(PH_WRREG);
            end else f_err = ERR_NO_WREN;
         end
         default: begin
            f_cmd = CMD_UNDEF; f_err = ERR_BAD_CMD; f_lane = LANE_SINGLE;
            enter_phase(PH_CMD);
         end
      endcase
   endfunction

   function automatic void clock_rise(logic [3:0] io);
      case (f_phase)
         PH_CMD: begin
            shift_in_bits(io, 1);
            if (f_bytes == 1) decode_opcode(f_sin);
         end
         PH_ADDR: begin
            shift_in_bits(io, lane_width());
            if (f_bits == 0) f_ptr = {f_ptr[PTR_W-9:0], f_sin};
            if (f_bytes == 3) begin
               if (f_cmd == CMD_DUAL || f_cmd == CMD_QUAD) enter_phase(PH_MODE);
               else enter_phase(PH_DATA);
            end
         end
         PH_MODE: begin
            shift_in_bits(io, lane_width());
            if (f_bytes == 1) begin
               f_cont = ((f_sin & CONT_MASK) == CONT_MATCH);
               if (f_cmd == CMD_QUAD) begin
                  enter_phase(PH_DUMMY); f_dummy = QUAD_DUMMY;
               end else begin
                  enter_phase(PH_DATA); f_dummy = 0;
               end
            end
         end
         PH_DUMMY: begin
            if (f_dummy <= 1) begin
               f_dummy = 0; enter_phase(PH_DATA);
            end else f_dummy--;
         end
         PH_WRREG: begin
            shift_in_bits(io, lane_width());
            if (f_bytes == 1) begin
               f_wen = 0; f_sr2 = f_sin;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void clock_fall();
      if (f_phase == PH_DATA) begin
         if (f_bits == 0) begin
            if (f_ptr < MEM_DEPTH && loaded[f_ptr[MEM_AW-1:0]]) begin
               f_sout = flash_img[f_ptr[MEM_AW-1:0]];
               f_ptr = f_ptr + 1'b1;
            end else begin
               f_err = ERR_UNDEF_RD;
               f_sout = 8'h00;
            end
         end
         f_dv = shift_out_bits();
      end else if (f_phase == PH_RDREG) f_dv = shift_out_bits();
   endfunction

   function automatic result_type predict_response(spi_sample_type s);
      result_type r;
      bit old_csn, old_clk;
      f_err = ERR_NONE;
      if (s.mode) begin
         flash_img[s.addr] = s.data;
         loaded[s.addr] = 1;
         r.io_out = f_dv;
      end else begin
         old_csn = f_last_csn;
         f_last_csn = s.csn;
         if (old_csn && s.csn) r.io_out = 4'd0;
         else begin
            old_clk = f_last_clk;
            f_last_clk = s.clk;
            if (s.csn && !old_csn) begin
               f_de = 4'd0;
               f_clk_rel = s.clk;
               if (f_bits != 0) f_err = ERR_PARTIAL;
            end else if (!s.csn && old_csn) begin
               f_phase = f_cont ? PH_ADDR : PH_CMD;
               if (!f_cont) begin
                  f_cmd = CMD_UNDEF; f_lane = LANE_SINGLE;
               end
               f_ptr = '0; f_sin = 8'h00; f_bytes = 0; f_bits = 0; f_de = 4'd0;
               if (f_was_sel && f_clk_rel != s.clk) f_err = ERR_CLOCK;
               f_was_sel = 1;
            end
            if (!s.csn && s.clk && !old_clk) begin
               clock_rise(s.io); f_dv = 4'd0;
            end else if (!s.csn && !s.clk && old_clk) clock_fall();
            r.io_out = f_dv;
         end
      end
      r.output_enable = f_de;
      r.error_code = f_err;
      r.status_two = f_sr2;
      return r;
   endfunction

   // stimulus building
   bit cont_armed;
   int cont_kind;

   task automatic put_word(bit m, bit csn, bit clk, logic [3:0] io,
                           logic [15:0] a, logic [7:0] d);
      spi_sample_type s;
      s.mode = m; s.csn = csn; s.clk = clk; s.io = io; s.addr = a; s.data = d;
      pending_samples.push_back(s);
   endtask

   task automatic put_pin(bit csn, bit clk, logic [3:0] io);
      int reps;
      reps = ($urandom_range(0, 7) == 0) ? 2 : 1;
      repeat (reps) put_word(0, csn, clk, io, 16'($urandom), 8'($urandom));
   endtask

   task automatic put_load(logic [15:0] a, logic [7:0] d);
      put_word(1, $urandom_range(0, 1), $urandom_range(0, 1), 4'($urandom), a, d);
      n_loads++;
   endtask

   task automatic shift_bits(int v, int nbits, int ln);
      int mask;
      logic [3:0] io;
      mask = (1 << ln) - 1;
      for (int i = nbits - ln; i >= 0; i -= ln) begin
         io = 4'((int'($urandom_range(0, 15)) & ~mask) | ((v >> i) & mask));
         put_pin(0, 0, io);
         put_pin(0, 1, io);
      end
   endtask

   task automatic run_clocks(int n);
      repeat (n) begin
         put_pin(0, 0, 4'($urandom));
         put_pin(0, 1, 4'($urandom));
      end
   endtask

   task automatic select_bus(bit lvl);
      put_pin(1, lvl, 4'($urandom));
      put_pin(0, lvl, 4'($urandom));
   endtask

   task automatic release_bus();
      put_pin(0, 0, 4'($urandom));
      put_pin(1, 0, 4'($urandom));
      put_pin(1, 0, 4'($urandom));
   endtask

   task automatic read_burst(int kind, logic [23:0] a, logic [7:0] mb, int nbytes, bit skip);
      int ln;
      ln = (kind == 0) ? 1 : (kind == 1) ? 2 : 4;
      select_bus(0);
      if (!skip) shift_bits((kind == 0) ? OP_READ : (kind == 1) ? OP_DUAL : OP_QUAD, 8, 1);
      shift_bits(a, 24, ln);
      if (kind > 0) shift_bits(mb, 8, ln);
      if (kind == 2) run_clocks(QUAD_DUMMY);
      run_clocks(nbytes * 8 / ln);
      release_bus();
      if (kind > 0) begin
         cont_armed = ((mb & CONT_MASK) == CONT_MATCH);
         cont_kind = kind;
      end
      n_reads++;
   endtask

   task automatic command_only(logic [7:0] op, int extra_bits);
      select_bus(0);
      shift_bits(op, 8, 1);
      run_clocks(extra_bits);
      release_bus();
      n_status++;
   endtask

   task automatic status_write(logic [7:0] v);
      select_bus(0);
      shift_bits(OP_WRSR2, 8, 1);
      shift_bits(v, 8, 1);
      release_bus();
      n_status++;
   endtask

   function automatic logic [23:0] pick_read_addr();
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return 24'($urandom_range(0, 127));
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   task automatic random_traffic();
      int r;
      logic [7:0] op;
      r = $urandom_range(0, 99);
      if (cont_armed && r < 85) begin
         read_burst(cont_kind, pick_read_addr(), 8'($urandom), $urandom_range(1, 4), 1);
         return;
      end
      if (r < 45)
         read_burst($urandom_range(0, 2), pick_read_addr(), 8'($urandom),
                    $urandom_range(1, 4), 0);
      else if (r < 55) command_only(OP_RDSR2, $urandom_range(4, 20));
      else if (r < 65) begin
         command_only(OP_WREN, 0);
         status_write(8'($urandom));
      end else if (r < 70) status_write(8'($urandom));
      else if (r < 75) begin
         op = 8'($urandom);
         command_only(op, $urandom_range(0, 10));
      end else if (r < 80) begin
         select_bus(0);
         run_clocks($urandom_range(1, 7));
         release_bus();
         n_faults++;
      end else if (r < 84) begin
         select_bus(1);
         run_clocks($urandom_range(0, 3));
         release_bus();
         n_faults++;
      end else if (r < 86) run_clocks($urandom_range(1, 4));
      else
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 7) == 0) put_load(16'($urandom), 8'($urandom));
            else put_load(16'($urandom_range(0, 127)), 8'($urandom));
         end
   endtask

   // clock and reset
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 0;
   end

   initial begin
      #20_000_000;
      $display("spi_flash_read_slave verification failed");
      $finish;
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         gap_left <= 0;
      end else if (!req_valid || taken) begin
         if (gap_left > 0) begin
            req_valid <= 0;
            gap_left <= gap_left - 1;
         end else if (pending_samples.size() > 0) begin
            cur_sample = pending_samples.pop_front();
            req_mode <= cur_sample.mode;
            req_pin_csn <= cur_sample.csn;
            req_pin_clk <= cur_sample.clk;
            req_io_in <= cur_sample.io;
            req_load_addr <= cur_sample.addr;
            req_load_data <= cur_sample.data;
            req_valid <= 1;
            gap_left <= pick_gap((accepted / 120) % 3 == 2);
         end else req_valid <= 0;
      end
   end

   // receiver, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_run <= 0;
         hold_left <= 0;
         hold_done <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted >= 150) begin
         hold_done <= 1;
         hold_left <= 80;
         rsp_stall <= 1;
      end else if (stall_run > 0) begin
         rsp_stall <= 1;
         stall_run <= stall_run - 1;
      end else begin
         int n;
         n = pick_gap((accepted / 120) % 3 == 0);
         rsp_stall <= (n > 0);
         stall_run <= (n > 0) ? n - 1 : 0;
      end
   end

   // acceptance, prediction and checking
   always @(posedge clock) begin
      if (reset) taken <= 0;
      else begin
         taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response word with none expected");
            end else begin
               result_type e;
               e = expected_responses.pop_front();
               checked++;
               if (rsp_io_out !== e.io_out || rsp_output_enable !== e.output_enable ||
                   rsp_error_code !== e.error_code || rsp_status_two !== e.status_two) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"word %0d: exp io %h oe %h err %0d sr2 %h, ",
                               "got io %h oe %h err %0d sr2 %h"},
                              checked, e.io_out, e.output_enable, e.error_code, e.status_two,
                              rsp_io_out, rsp_output_enable, rsp_error_code, rsp_status_two);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_responses.push_back(predict_response(cur_sample));
            accepted++;
         end
      end
   end

   initial begin
      req_valid = 0; req_mode = 0; req_pin_csn = 1; req_pin_clk = 0; req_io_in = 0;
      req_load_addr = 0; req_load_data = 0; rsp_stall = 0;
      f_last_csn = 1; f_last_clk = 0; f_clk_rel = 0; f_was_sel = 0;
      f_phase = PH_CMD; f_cmd = CMD_UNDEF; f_lane = LANE_SINGLE; f_ptr = '0;
      f_sin = 0; f_sout = 0; f_sr2 = 0; f_bits = 0; f_bytes = 0; f_dummy = 0;
      f_cont = 0; f_wen = 0; f_de = 0; f_dv = 0;
      for (int i = 0; i < MEM_DEPTH; i++) loaded[i] = 0;

      // directed sequences
      put_load(16'h0000, 8'h00);
      put_load(16'h0001, 8'hff);
      for (int i = 2; i < 8; i++) put_load(16'(i), 8'($urandom));
      put_load(16'hffff, 8'ha5);
      read_burst(2, 24'h000000, 8'h25, 2, 0);
      read_burst(2, 24'h00ffff, 8'h10, 2, 1);
      read_burst(0, 24'h000006, 8'h00, 2, 0);
      command_only(OP_RDSR2, 8);
      status_write(8'h5a);
      command_only(OP_WREN, 0);
      status_write(8'hff);
      read_burst(1, 24'h000000, 8'h20, 2, 0);
      read_burst(1, 24'h000002, 8'h00, 1, 1);
      command_only(8'h00, 3);
      select_bus(0);
      run_clocks(5);
      release_bus();
      select_bus(1);
      release_bus();
      n_faults += 2;

      while (pending_samples.size() < 560) random_traffic();

      @(negedge reset);
      do @(posedge clock);
      while (pending_samples.size() > 0 || req_valid || expected_responses.size() > 0);
      repeat (10) @(posedge clock);
      $display("%0d response words checked over %0d reads, %0d register commands,",
               checked, n_reads, n_status);
      $display("%0d flash loads and %0d framing faults", n_loads, n_faults);
      if (mismatches == 0 && expected_responses.size() == 0)
         $display("spi_flash_read_slave verification clean");
      else
         $display("spi_flash_read_slave verification failed");
      $finish;
   end

endmodule
